FILE: rtl/afp_pkg.sv
// Package: shared types, constants and the byte-wide CRC-16 update of the AF packet framer.
package afp_pkg;

  localparam logic [7:0]  SYNC_A      = 8'h41;
  localparam logic [7:0]  SYNC_F      = 8'h46;
  localparam logic [7:0]  AF_VERSION  = 8'h10;
  localparam logic [7:0]  AF_CRC_BIT  = 8'h80;
  localparam logic [7:0]  AF_TYPE     = 8'h54;
  localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [3:0]  HDR_LAST    = 4'd9;

  localparam logic [3:0]  HDR_SYNC_A  = 4'd0;
  localparam logic [3:0]  HDR_SYNC_F  = 4'd1;
  localparam logic [3:0]  HDR_LEN_3   = 4'd2;
  localparam logic [3:0]  HDR_LEN_2   = 4'd3;
  localparam logic [3:0]  HDR_LEN_1   = 4'd4;
  localparam logic [3:0]  HDR_LEN_0   = 4'd5;
  localparam logic [3:0]  HDR_SEQ_1   = 4'd6;
  localparam logic [3:0]  HDR_SEQ_0   = 4'd7;
  localparam logic [3:0]  HDR_FLAGS   = 4'd8;
  localparam logic [3:0]  HDR_TYPE    = 4'd9;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

  typedef struct packed {
    logic        is_hdr;
    logic        add_crc;
    logic [31:0] len;
    logic [15:0] seq;
    logic [7:0]  data;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/afp_in_if.sv
// Interface: input item channel (start or payload byte).
interface afp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, output func, output payload_length, output payload_byte,
                  input ready);
  modport sink (input valid, input func, input payload_length, input payload_byte,
                output ready);
endinterface

FILE: rtl/afp_out_if.sv
// Interface: framed byte output channel.
interface afp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;

  modport source (output valid, output out_byte, output packet_end, input ready);
  modport sink (input valid, input out_byte, input packet_end, output ready);
endinterface

FILE: rtl/afp_cfg_if.sv
// Interface: configuration write channel for the CRC flag register.
interface afp_cfg_if;
  logic valid;
  logic ready;
  logic crc_flag;

  modport source (output valid, output crc_flag, input ready);
  modport sink (input valid, input crc_flag, output ready);
endinterface

FILE: rtl/afp_emit.sv
// Byte emitter: header, payload and CRC byte sequencing with CRC update and output register.
module afp_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          crc_flag_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  afp_pkg::job_t job_i,
  afp_out_if.source     out_o
);
  import afp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  job_t        job_q;
  logic [15:0] crc_q, crc_d;
  logic        ovld_q;
  logic [7:0]  obyte_q;
  logic        oend_q;

  logic        adv;
  logic        last;
  logic        take;
  logic [7:0]  cur;
  logic        cur_end;
  logic [15:0] crc_base;
  logic [7:0]  flags;

  assign flags = (crc_flag_i ? AF_CRC_BIT : 8'h00) | AF_VERSION;

  always_comb begin
    adv      = (phase_q != PH_IDLE) && (!ovld_q || out_o.ready);
    cur      = 8'h00;
    cur_end  = 1'b0;
    last     = 1'b0;
    crc_base = crc_q;
    case (phase_q)
      PH_HDR: begin
        if (idx_q == HDR_SYNC_A) crc_base = CRC_PRESET;
        case (idx_q)
          HDR_SYNC_A: cur = SYNC_A;
          HDR_SYNC_F: cur = SYNC_F;
          HDR_LEN_3:  cur = job_q.len[31:24];
          HDR_LEN_2:  cur = job_q.len[23:16];
          HDR_LEN_1:  cur = job_q.len[15:8];
          HDR_LEN_0:  cur = job_q.len[7:0];
          HDR_SEQ_1:  cur = job_q.seq[15:8];
          HDR_SEQ_0:  cur = job_q.seq[7:0];
          HDR_FLAGS:  cur = flags;
          HDR_TYPE:   cur = AF_TYPE;
          default:    cur = 8'h00;
        endcase
        last = (idx_q == HDR_LAST) && !job_q.add_crc;
      end
      PH_DATA: begin
        cur  = job_q.data;
        last = !job_q.add_crc;
      end
      PH_CRC_HI: begin
        cur = ~crc_q[15:8];
      end
      PH_CRC_LO: begin
        cur     = ~crc_q[7:0];
        cur_end = 1'b1;
        last    = 1'b1;
      end
      default: begin
        cur = 8'h00;
      end
    endcase
  end

  assign job_ready_o = (phase_q == PH_IDLE) || (adv && last);
  assign take        = job_valid_i && job_ready_o;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    if (adv) begin
      case (phase_q)
        PH_HDR: begin
          crc_d = crc16_byte(crc_base, cur);
          if (idx_q == HDR_LAST) begin
            phase_d = PH_CRC_HI;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_DATA: begin
          crc_d   = crc16_byte(crc_base, cur);
          phase_d = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase_d = PH_CRC_LO;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    if (job_ready_o) begin
      idx_d   = '0;
      phase_d = take ? (job_i.is_hdr ? PH_HDR : PH_DATA) : PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      crc_q   <= CRC_PRESET;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      if (adv) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_i;
    end
    if (adv) begin
      obyte_q <= cur;
      oend_q  <= cur_end;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.packet_end = oend_q;

  a_hdr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HDR) |-> (idx_q <= HDR_LAST))
    else $error("header index beyond type byte");

  a_crc_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CRC_HI || phase_q == PH_CRC_LO) |-> job_q.add_crc)
    else $error("CRC bytes sent for a job without CRC");

  a_crc_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && phase_q == PH_CRC_HI) |=> (phase_q == PH_CRC_LO && ovld_q && !oend_q))
    else $error("CRC high byte not followed by CRC low byte");

endmodule

FILE: rtl/af_packet_framer_crc16_core.sv
// Top level: AF packet framer with CRC-16, packet tracking and configuration register.
//
//   channel  | dir | transfer                        | payload
//   in_i     | in  | start (length) or payload byte  | func, payload_length, payload_byte
//   out_o    | out | one byte of the framed packet   | out_byte, packet_end
//   cfg_i    | in  | CRC flag register write         | crc_flag
//
// A start item yields 10 or 12 bytes and a payload byte 1 or 3, so input items are taken
// at the rate the emitter drains its byte sequence.
// A payload byte with no open packet is taken as soon as the emitter can take a job
// and yields nothing.
// The CRC is updated one byte per cycle while the output is not stalled; the output
// register holds a byte under stall while the next item is already taken. Reset closes
// any packet, clears the sequence number and sets the CRC flag.
module af_packet_framer_crc16_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  afp_in_if.sink    in_i,
  afp_out_if.source out_o,
  afp_cfg_if.sink   cfg_i
);
  import afp_pkg::*;

  logic        crc_flag_q;
  logic [15:0] seq_q;
  logic [31:0] rem_q;
  logic        open_q;

  job_t        job;
  logic        job_valid;
  logic        job_ready;
  logic        in_fire;
  logic        is_start;

  assign cfg_i.ready = 1'b1;

  assign is_start    = (func_e'(in_i.func) == FUNC_START);
  assign job.is_hdr  = is_start;
  assign job.add_crc = is_start ? (in_i.payload_length == 32'd0) : (rem_q == 32'd1);
  assign job.len     = in_i.payload_length;
  assign job.seq     = seq_q;
  assign job.data    = in_i.payload_byte;
  assign job_valid   = in_i.valid && (is_start || open_q);
  assign in_i.ready  = job_ready;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_flag_q <= 1'b1;
      seq_q      <= '0;
      rem_q      <= '0;
      open_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        crc_flag_q <= cfg_i.crc_flag;
      end
      if (in_fire) begin
        if (is_start) begin
          seq_q  <= seq_q + 16'd1;
          rem_q  <= in_i.payload_length;
          open_q <= (in_i.payload_length != 32'd0);
        end else if (open_q) begin
          rem_q <= rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            open_q <= 1'b0;
          end
        end
      end
    end
  end

  afp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .crc_flag_i  (crc_flag_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_o       (out_o)
  );

  a_open_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (rem_q != 32'd0))
    else $error("open packet with no bytes remaining");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_start && !open_q) |=> (seq_q == $past(seq_q) && !open_q))
    else $error("dropped byte changed packet state");

  a_start_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_start && in_i.payload_length != 32'd0) |=> open_q)
    else $error("start with nonzero length left no packet open");

endmodule

FILE: bench/af_packet_framer_crc16_core_test.sv
// Testbench: AF packet framer with CRC-16, predicted byte stream checked against the output.
module af_packet_framer_crc16_core_test;
  import afp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned MAX_WAIT     = 14;

  typedef struct {
    func_e       op;
    logic [31:0] len;
    logic [7:0]  data;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } framed_byte_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  afp_in_if  in_ch ();
  afp_out_if out_ch ();
  afp_cfg_if cfg_ch ();

  af_packet_framer_crc16_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  logic        src_valid = 1'b0;
  func_e       src_op    = FUNC_START;
  logic [31:0] src_len   = '0;
  logic [7:0]  src_data  = '0;
  logic        sink_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_flag  = 1'b0;

  assign in_ch.valid          = src_valid;
  assign in_ch.func           = src_op;
  assign in_ch.payload_length = src_len;
  assign in_ch.payload_byte   = src_data;
  assign out_ch.ready         = sink_ready;
  assign cfg_ch.valid         = cfg_valid;
  assign cfg_ch.crc_flag      = cfg_flag;

  framer_item_t pending_items[$];
  framed_byte_t framed_bytes_q[$];
  framer_item_t next_item;

  logic        flag_crc   = 1'b1;
  logic [15:0] seq_num    = '0;
  logic [15:0] crc_acc    = CRC_PRESET;
  logic [31:0] remaining  = '0;
  logic        pkt_open   = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_gap        = 0;
  int unsigned sink_stall     = 0;
  bit          src_burst      = 1'b0;
  bit          sink_burst     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait(ref bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void push_framed(input logic [7:0] b);
    crc_acc = crc_ccitt_next(crc_acc, b);
    framed_bytes_q.insert(framed_bytes_q.size(), framed_byte_t'{data: b, last: 1'b0});
  endfunction

  function automatic void close_with_crc();
    logic [15:0] c;
    c = ~crc_acc;
    framed_bytes_q.insert(framed_bytes_q.size(), framed_byte_t'{data: c[15:8], last: 1'b0});
    framed_bytes_q.insert(framed_bytes_q.size(), framed_byte_t'{data: c[7:0], last: 1'b1});
    pkt_open  = 1'b0;
    remaining = '0;
    crc_acc   = CRC_PRESET;
  endfunction

  function automatic void frame_item(input func_e op, input logic [31:0] len,
                                     input logic [7:0] b);
    if (op == FUNC_START) begin
      crc_acc = CRC_PRESET;
      push_framed(SYNC_A);
      push_framed(SYNC_F);
      push_framed(len[31:24]);
      push_framed(len[23:16]);
      push_framed(len[15:8]);
      push_framed(len[7:0]);
      push_framed(seq_num[15:8]);
      push_framed(seq_num[7:0]);
      seq_num = seq_num + 16'd1;
      push_framed((flag_crc ? AF_CRC_BIT : 8'h00) | AF_VERSION);
      push_framed(AF_TYPE);
      remaining = len;
      pkt_open  = 1'b1;
      if (len == 32'd0) close_with_crc();
    end else if (pkt_open) begin
      push_framed(b);
      remaining = remaining - 32'd1;
      if (remaining == 32'd0) close_with_crc();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // drive input transfers from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_gap = 0;
    end else if (!src_valid || in_ch.ready) begin
      if (src_valid) begin
        frame_item(src_op, src_len, src_data);
        src_gap = draw_wait(src_burst);
      end
      if (src_gap > 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        src_valid <= 1'b1;
        src_op    <= next_item.op;
        src_len   <= next_item.len;
        src_data  <= next_item.data;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // accept output transfers and compare against the predicted stream
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        if (framed_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end %0b",
                                    out_ch.out_byte, out_ch.packet_end));
        end else begin
          framed_byte_t exp_byte;
          exp_byte = framed_bytes_q.pop_front();
          if (out_ch.out_byte !== exp_byte.data)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      out_ch.out_byte, exp_byte.data));
          if (out_ch.packet_end !== exp_byte.last)
            report_mismatch($sformatf("packet_end %0b, predicted %0b on byte %02h",
                                      out_ch.packet_end, exp_byte.last, exp_byte.data));
        end
        sink_stall = draw_wait(sink_burst);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input func_e op, input logic [31:0] len, input logic [7:0] b);
    pending_items.insert(pending_items.size(), framer_item_t'{op: op, len: len, data: b});
  endtask

  task automatic push_payload(input int unsigned n);
    repeat (n) push_item(FUNC_DATA, $urandom, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_crc_flag(input logic value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_flag  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    flag_crc = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || src_valid || framed_bytes_q.size() > 0)
      @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    push_item(FUNC_DATA, 32'hFFFF_FFFF, 8'hFF);
    push_item(FUNC_START, 32'd0, 8'hFF);
    push_item(FUNC_START, 32'd1, 8'h00);
    push_item(FUNC_DATA, 32'd0, 8'h00);
    push_item(FUNC_START, 32'd2, 8'hFF);
    push_item(FUNC_DATA, 32'hFFFF_FFFF, 8'hFF);
    push_item(FUNC_DATA, 32'h0000_0000, 8'hA5);
    push_item(FUNC_DATA, 32'd0, 8'h5A);
    push_item(FUNC_START, 32'hFFFF_FFFF, 8'h00);
    push_item(FUNC_DATA, 32'd0, 8'h5A);
    push_item(FUNC_START, 32'd1, 8'h00);
    push_item(FUNC_DATA, 32'd0, 8'h3C);
    push_item(FUNC_START, 32'h8000_0000, 8'h00);
    push_item(FUNC_DATA, 32'd0, 8'h80);
    push_item(FUNC_START, 32'd0, 8'h00);
    push_item(FUNC_START, 32'h0001_0000, 8'h00);
    push_item(FUNC_START, 32'd3, 8'h00);
    push_item(FUNC_DATA, 32'd0, 8'h01);
    push_item(FUNC_DATA, 32'd0, 8'h7F);
    push_item(FUNC_DATA, 32'd0, 8'hFE);
  endtask

  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned queued;
    int unsigned pick;
    int unsigned len;
    int unsigned sent;
    logic [31:0] big_len;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        push_item(FUNC_START, len, 8'($urandom_range(0, 255)));
        push_payload(len);
        queued += len + 1;
      end else if (pick < 80) begin
        big_len = $urandom | 32'h0000_0010;
        sent    = $urandom_range(0, 5);
        push_item(FUNC_START, big_len, 8'($urandom_range(0, 255)));
        push_payload(sent);
        queued += sent + 1;
      end else if (pick < 90) begin
        push_payload(1);
        queued += 1;
      end else begin
        len  = $urandom_range(2, 8);
        sent = $urandom_range(0, len - 1);
        push_item(FUNC_START, len, 8'($urandom_range(0, 255)));
        push_payload(sent);
        queued += sent + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    wait_idle();
    write_crc_flag(1'b0);
    queue_random_traffic(70);
    wait_idle();
    write_crc_flag(1'b1);
    queue_random_traffic(70);
    wait_idle();
    write_crc_flag(1'b0);
    queue_random_traffic(60);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/afp_pkg.sv
rtl/afp_in_if.sv
rtl/afp_out_if.sv
rtl/afp_cfg_if.sv
rtl/afp_emit.sv
rtl/af_packet_framer_crc16_core.sv
bench/af_packet_framer_crc16_core_test.sv
